// ===== rtl/tpwd_pkg.sv =====
// Shared widths, stage records and the flat-pixel phase table for the wrapped-phase decoder.
package tpwd_pkg;

  localparam int SampleW  = 8;
  localparam int SumW     = 10;
  localparam int TolW     = 17;
  localparam int PhaseW   = 17;
  localparam int DenW     = 11;
  localparam int OffW     = 3;
  localparam int StepBits = 4;
  localparam int DivSteps = 4;
  localparam int ProdW    = TolW + SumW;

  localparam logic [OffW-1:0] OFF_ZERO  = 3'd0;
  localparam logic [OffW-1:0] OFF_TWO   = 3'd2;
  localparam logic [OffW-1:0] OFF_FOUR  = 3'd4;
  localparam logic [OffW-1:0] OFF_SIX   = 3'd6;

  typedef struct packed {
    logic                valid;
    logic [SampleW-1:0]  range;
    logic [SampleW-1:0]  diff;
    logic [SumW-1:0]     sum;
    logic [OffW-1:0]     off;
    logic                neg;
  } sort_t;

  typedef struct packed {
    logic                valid;
    logic                masked;
    logic                flat;
    logic [DenW-1:0]     den;
    logic [DenW-1:0]     rem;
    logic [PhaseW-1:0]   quot;
  } div_t;

  function automatic logic [PhaseW-1:0] flat_phase(input logic [OffW-1:0] off);
    logic [PhaseW-1:0] p;
    case (off)
      OFF_TWO:  p = 17'd21845;
      OFF_FOUR: p = 17'd43690;
      OFF_SIX:  p = 17'd65536;
      default:  p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/tpwd_sort.sv =====
// First stage: orders the three samples and registers range, median offset, sum and case.
module tpwd_sort (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [tpwd_pkg::SampleW-1:0]      sample_a,
  input  logic [tpwd_pkg::SampleW-1:0]      sample_b,
  input  logic [tpwd_pkg::SampleW-1:0]      sample_c,
  output tpwd_pkg::sort_t                   sort_r
);

  tpwd_pkg::sort_t               sort_nxt;
  logic [tpwd_pkg::SampleW-1:0]  mx;
  logic [tpwd_pkg::SampleW-1:0]  md;
  logic [tpwd_pkg::SampleW-1:0]  mn;

  always_comb begin
    sort_nxt       = '0;
    sort_nxt.valid = in_valid;
    if (sample_b <= sample_c && sample_c <= sample_a) begin
      mx = sample_a; md = sample_c; mn = sample_b;
      sort_nxt.off = tpwd_pkg::OFF_ZERO; sort_nxt.neg = 1'b0;
    end else if (sample_b <= sample_a && sample_a <= sample_c) begin
      mx = sample_c; md = sample_a; mn = sample_b;
      sort_nxt.off = tpwd_pkg::OFF_TWO; sort_nxt.neg = 1'b1;
    end else if (sample_a <= sample_b && sample_b <= sample_c) begin
      mx = sample_c; md = sample_b; mn = sample_a;
      sort_nxt.off = tpwd_pkg::OFF_TWO; sort_nxt.neg = 1'b0;
    end else if (sample_a <= sample_c && sample_c <= sample_b) begin
      mx = sample_b; md = sample_c; mn = sample_a;
      sort_nxt.off = tpwd_pkg::OFF_FOUR; sort_nxt.neg = 1'b1;
    end else if (sample_c <= sample_a && sample_a <= sample_b) begin
      mx = sample_b; md = sample_a; mn = sample_c;
      sort_nxt.off = tpwd_pkg::OFF_FOUR; sort_nxt.neg = 1'b0;
    end else begin
      mx = sample_a; md = sample_b; mn = sample_c;
      sort_nxt.off = tpwd_pkg::OFF_SIX; sort_nxt.neg = 1'b1;
    end
    sort_nxt.range = mx - mn;
    sort_nxt.diff  = md - mn;
    sort_nxt.sum   = tpwd_pkg::SumW'(sample_a) + tpwd_pkg::SumW'(sample_b)
                   + tpwd_pkg::SumW'(sample_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_r <= '0;
    end else begin
      sort_r <= sort_nxt;
    end
  end

endmodule

// ===== rtl/tpwd_prep.sv =====
// Second stage: contrast test, numerator and divisor, and the top quotient bit.
module tpwd_prep (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpwd_pkg::sort_t                sort_i,
  input  logic [tpwd_pkg::TolW-1:0]      tol,
  output tpwd_pkg::div_t                 div_r
);

  tpwd_pkg::div_t                  div_nxt;
  logic [tpwd_pkg::ProdW-1:0]      limit;
  logic [tpwd_pkg::ProdW-1:0]      scaled;
  logic [tpwd_pkg::DenW-1:0]       offr;
  logic [tpwd_pkg::DenW-1:0]       num;
  logic                            top_bit;

  always_comb begin
    limit  = tpwd_pkg::ProdW'(tol) * tpwd_pkg::ProdW'(sort_i.sum);
    scaled = tpwd_pkg::ProdW'({sort_i.range, 16'b0});
    offr   = tpwd_pkg::DenW'(sort_i.off) * tpwd_pkg::DenW'(sort_i.range);
    if (sort_i.neg) begin
      num = offr - tpwd_pkg::DenW'(sort_i.diff);
    end else begin
      num = offr + tpwd_pkg::DenW'(sort_i.diff);
    end
    div_nxt        = '0;
    div_nxt.valid  = sort_i.valid;
    div_nxt.masked = scaled < limit;
    div_nxt.flat   = (sort_i.range == '0);
    div_nxt.den    = tpwd_pkg::DenW'({sort_i.range, 2'b0})
                   + tpwd_pkg::DenW'({sort_i.range, 1'b0});
    top_bit        = (num == div_nxt.den);
    if (div_nxt.flat) begin
      div_nxt.quot = tpwd_pkg::flat_phase(sort_i.off);
      div_nxt.rem  = '0;
    end else begin
      div_nxt.quot = tpwd_pkg::PhaseW'(top_bit);
      div_nxt.rem  = top_bit ? '0 : num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

endmodule

// ===== rtl/tpwd_div_step.sv =====
// One divider stage: four restoring quotient bits per request, registered.
module tpwd_div_step (
  input  logic              clk,
  input  logic              rst_n,
  input  tpwd_pkg::div_t    div_i,
  output tpwd_pkg::div_t    div_r
);

  tpwd_pkg::div_t                  div_nxt;
  logic [tpwd_pkg::DenW-1:0]       rem;
  logic [tpwd_pkg::DenW:0]         wide;
  logic [tpwd_pkg::StepBits-1:0]   bits;

  always_comb begin
    div_nxt = div_i;
    rem     = div_i.rem;
    bits    = '0;
    wide    = '0;
    for (int i = tpwd_pkg::StepBits - 1; i >= 0; i--) begin
      wide = {rem, 1'b0};
      if (wide >= {1'b0, div_i.den}) begin
        bits[i] = 1'b1;
        wide    = wide - {1'b0, div_i.den};
      end
      rem = wide[tpwd_pkg::DenW-1:0];
    end
    if (!div_i.flat) begin
      div_nxt.rem  = rem;
      div_nxt.quot = {div_i.quot[tpwd_pkg::PhaseW-tpwd_pkg::StepBits-1:0], bits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

endmodule

// ===== rtl/three_phase_wrap_decoder.sv =====
// Top level of the three-step wrapped-phase decoder: sort, prepare, divide, output register.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | in_sample_a, in_sample_b, in_sample_c   | start high, busy low
//  result   | out_masked, out_wrapped_phase           | out_strobe for one cycle
//  config   | cfg_wr_data                             | cfg_wr_en, no wait
//
// One request is taken every cycle; busy is always low.
// Each result passes, in order, one sort stage, which captures at the edge that accepts its
// request, one preparation stage, four divider stages of four quotient bits each, and the
// output register.
// Reset clears the valid bits of every stage and sets the tolerance to zero.
// The receiver cannot stall, so the pipeline never holds.
module three_phase_wrap_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tpwd_pkg::SampleW-1:0]      in_sample_a,
  input  logic [tpwd_pkg::SampleW-1:0]      in_sample_b,
  input  logic [tpwd_pkg::SampleW-1:0]      in_sample_c,
  output logic                              out_strobe,
  output logic                              out_masked,
  output logic [tpwd_pkg::PhaseW-1:0]       out_wrapped_phase,
  input  logic                              cfg_wr_en,
  input  logic [tpwd_pkg::TolW-1:0]         cfg_wr_data
);

  logic [tpwd_pkg::TolW-1:0]    tol_r;
  tpwd_pkg::sort_t              sort_r;
  tpwd_pkg::div_t               div_s [tpwd_pkg::DivSteps+1];
  logic                         strobe_r;
  logic                         masked_r;
  logic [tpwd_pkg::PhaseW-1:0]  phase_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  tpwd_sort u_sort (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .sample_a (in_sample_a),
    .sample_b (in_sample_b),
    .sample_c (in_sample_c),
    .sort_r   (sort_r)
  );

  tpwd_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .sort_i (sort_r),
    .tol    (tol_r),
    .div_r  (div_s[0])
  );

  for (genvar g = 0; g < tpwd_pkg::DivSteps; g++) begin : g_div
    tpwd_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .div_i (div_s[g]),
      .div_r (div_s[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= div_s[tpwd_pkg::DivSteps].valid;
    end
  end

  always_ff @(posedge clk) begin
    masked_r <= div_s[tpwd_pkg::DivSteps].masked;
    phase_r  <= div_s[tpwd_pkg::DivSteps].masked ? '0 : div_s[tpwd_pkg::DivSteps].quot;
  end

  assign out_strobe        = strobe_r;
  assign out_masked        = masked_r;
  assign out_wrapped_phase = phase_r;

endmodule

// ===== tb/tb_three_phase_wrap_decoder.sv =====
// Self-checking testbench for the three-step wrapped-phase decoder with directed and randomised pixels.
module tb_three_phase_wrap_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [tpwd_pkg::SampleW-1:0] a;
    logic [tpwd_pkg::SampleW-1:0] b;
    logic [tpwd_pkg::SampleW-1:0] c;
  } pixel_t;

  typedef struct {
    logic                        masked;
    logic [tpwd_pkg::PhaseW-1:0] phase;
  } phase_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [tpwd_pkg::SampleW-1:0]  in_sample_a = '0;
  logic [tpwd_pkg::SampleW-1:0]  in_sample_b = '0;
  logic [tpwd_pkg::SampleW-1:0]  in_sample_c = '0;
  logic                          out_strobe;
  logic                          out_masked;
  logic [tpwd_pkg::PhaseW-1:0]   out_wrapped_phase;
  logic                          cfg_wr_en = 1'b0;
  logic [tpwd_pkg::TolW-1:0]     cfg_wr_data = '0;

  pixel_t         pixels_to_send[$];
  phase_result_t  phases_due[$];
  logic [tpwd_pkg::TolW-1:0] tolerance = '0;
  int unsigned    sender_idle_pct = 28;
  int unsigned    requests_sent = 0;
  int unsigned    results_checked = 0;
  int unsigned    masked_seen = 0;
  int unsigned    tolerances_used = 1;
  int unsigned    mismatches = 0;

  three_phase_wrap_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_sample_c       (in_sample_c),
    .out_strobe        (out_strobe),
    .out_masked        (out_masked),
    .out_wrapped_phase (out_wrapped_phase),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic phase_result_t decode_pixel(input pixel_t px,
                                                 input logic [tpwd_pkg::TolW-1:0] tol);
    logic [tpwd_pkg::SampleW-1:0] hi;
    logic [tpwd_pkg::SampleW-1:0] mid;
    logic [tpwd_pkg::SampleW-1:0] lo;
    logic [tpwd_pkg::OffW-1:0]    off;
    logic                         neg;
    longint unsigned              spread;
    longint unsigned              total;
    longint unsigned              num;
    phase_result_t                r;
    if (px.b <= px.c && px.c <= px.a) begin
      hi = px.a; mid = px.c; lo = px.b; off = tpwd_pkg::OFF_ZERO; neg = 1'b0;
    end else if (px.b <= px.a && px.a <= px.c) begin
      hi = px.c; mid = px.a; lo = px.b; off = tpwd_pkg::OFF_TWO; neg = 1'b1;
    end else if (px.a <= px.b && px.b <= px.c) begin
      hi = px.c; mid = px.b; lo = px.a; off = tpwd_pkg::OFF_TWO; neg = 1'b0;
    end else if (px.a <= px.c && px.c <= px.b) begin
      hi = px.b; mid = px.c; lo = px.a; off = tpwd_pkg::OFF_FOUR; neg = 1'b1;
    end else if (px.c <= px.a && px.a <= px.b) begin
      hi = px.b; mid = px.a; lo = px.c; off = tpwd_pkg::OFF_FOUR; neg = 1'b0;
    end else begin
      hi = px.a; mid = px.b; lo = px.c; off = tpwd_pkg::OFF_SIX; neg = 1'b1;
    end
    spread = longint'(hi) - longint'(lo);
    total = longint'(px.a) + longint'(px.b) + longint'(px.c);
    r.masked = (spread * 65536) < (longint'(tol) * total);
    if (r.masked) begin
      r.phase = '0;
    end else if (spread == 0) begin
      r.phase = tpwd_pkg::PhaseW'((longint'(off) * 65536) / 6);
    end else begin
      num = longint'(off) * spread;
      if (neg) begin
        num = num - (longint'(mid) - longint'(lo));
      end else begin
        num = num + (longint'(mid) - longint'(lo));
      end
      r.phase = tpwd_pkg::PhaseW'((num * 65536) / (6 * spread));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_t px;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        px.a = in_sample_a;
        px.b = in_sample_b;
        px.c = in_sample_c;
        phases_due.insert(phases_due.size(), decode_pixel(px, tolerance));
        requests_sent++;
      end
      if ((!start || !busy) && pixels_to_send.size() > 0
          && $urandom_range(99) >= sender_idle_pct) begin
        px = pixels_to_send[0];
        pixels_to_send.delete(0);
        start       <= 1'b1;
        in_sample_a <= px.a;
        in_sample_b <= px.b;
        in_sample_c <= px.c;
      end else if (!start || !busy) begin
        start       <= 1'b0;
        in_sample_a <= 8'($urandom);
        in_sample_b <= 8'($urandom);
        in_sample_c <= 8'($urandom);
      end
    end
  end

  always @(posedge clk) begin
    phase_result_t want;
    if (rst_n && out_strobe) begin
      results_checked++;
      if (out_masked) masked_seen++;
      if (phases_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result with no request outstanding: masked=%0d phase=%0d",
                   out_masked, out_wrapped_phase);
        end
      end else begin
        want = phases_due[0];
        phases_due.delete(0);
        if (out_masked !== want.masked || out_wrapped_phase !== want.phase) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected masked=%0d phase=%0d, got masked=%0d phase=%0d",
                     $realtime, want.masked, want.phase, out_masked, out_wrapped_phase);
          end
        end
      end
    end
  end

  task automatic queue_pixel(input int a, input int b, input int c);
    pixel_t px;
    px.a = tpwd_pkg::SampleW'(a);
    px.b = tpwd_pkg::SampleW'(b);
    px.c = tpwd_pkg::SampleW'(c);
    pixels_to_send.insert(pixels_to_send.size(), px);
  endtask

  task automatic queue_random_pixel();
    int base;
    int mode;
    mode = $urandom_range(9);
    base = $urandom_range(255);
    case (mode)
      5: queue_pixel(base, base, $urandom_range(255));
      6: queue_pixel(base, base, base);
      7: queue_pixel(255 * $urandom_range(1), 255 * $urandom_range(1), 255 * $urandom_range(1));
      8: queue_pixel(base, (base + $urandom_range(6)) % 256, (base + $urandom_range(6)) % 256);
      9: queue_pixel($urandom_range(255), base, base);
      default: queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endcase
  endtask

  task automatic wait_until_drained();
    do @(posedge clk);
    while (!(pixels_to_send.size() == 0 && !start && phases_due.size() == 0));
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [tpwd_pkg::TolW-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= tpwd_pkg::TolW'($urandom);
    tolerance = value;
    tolerances_used++;
  endtask

  initial begin
    logic [tpwd_pkg::TolW-1:0] settings[6];
    settings[0] = 17'd13107;
    settings[1] = 17'd0;
    settings[2] = 17'd65536;
    settings[3] = 17'd131071;
    settings[4] = 17'd1;
    settings[5] = tpwd_pkg::TolW'($urandom_range(40000));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(200, 10, 100);
    queue_pixel(100, 10, 200);
    queue_pixel(10, 100, 200);
    queue_pixel(10, 200, 100);
    queue_pixel(100, 200, 10);
    queue_pixel(200, 100, 10);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(255, 0, 128);
    queue_pixel(1, 0, 0);
    queue_pixel(50, 50, 49);
    queue_pixel(49, 50, 50);
    queue_pixel(50, 49, 50);
    queue_pixel(254, 255, 253);
    wait_until_drained();

    for (int p = 0; p < 6; p++) begin
      sender_idle_pct = (p < 2) ? 28 : (p < 4) ? 81 : 0;
      write_tolerance(settings[p]);
      for (int i = 0; i < 275; i++) queue_random_pixel();
      wait_until_drained();
    end

    $display("Covered %0d pixel requests and %0d results (%0d masked) over %0d tolerance settings,",
             requests_sent, results_checked, masked_seen, tolerances_used);
    $display("with tolerances from zero to above one and sender gaps at three densities.");
    if (phases_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb_three_phase_wrap_decoder: PASS");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("tb_three_phase_wrap_decoder: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", phases_due.size());
    $display("tb_three_phase_wrap_decoder: FAIL");
    $finish;
  end

endmodule
